>>> rtl/core/ssdm_pkg.sv
// shared constants, types and the hex glyph table of the seven-segment display driver
package ssdm_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int CUR_W = $clog2(DIGIT_COUNT + 1);

  localparam int ACTION_W = 3;
  localparam int DATA_W = 8;
  localparam int SEG_W = 8;
  localparam int EN_OUT_W = 4;
  localparam int CUR_OUT_W = 3;

  localparam logic [ACTION_W-1:0] ACT_CHAR = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_HEX = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DEC = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DEC_BLANK = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_HOME = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_TICK = 3'd6;

  localparam logic [DATA_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [DATA_W-1:0] CHAR_POINT = 8'h2E;

  localparam logic [6:0] DEC_MAX = 7'd99;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_G = 8'h40;
  localparam logic [SEG_W-1:0] SEG_DP = 8'h80;

  typedef struct packed {
    logic accept;
    logic second;
    logic load_out;
  } ssdm_cmd_t;

  function automatic logic [SEG_W-1:0] hex_glyph(input logic [3:0] nib);
    logic [SEG_W-1:0] g;
    case (nib)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h77;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h39;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/core/seven_segment_display_mux.sv
// top level of the multiplexed seven-segment display driver
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid_i/in_ready_o | action_i[2:0], data_i[7:0]
//  out     | out_valid_o/out_ready_i | segments_o[7:0], digit_enables_o[3:0],
//          |                       | cursor_o[2:0], refreshed_o
//
// char, home, clear and tick items act on accept; hex and decimal items write
// two glyphs through the single store write port, the second one in ST_SECOND
// one result register sits on the output, so an item is accepted while the last
// result still waits; the item then holds until that register frees up
// reset clears the store and cursor, turns all digits off, empties the output
module seven_segment_display_mux (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ssdm_pkg::ACTION_W-1:0]   action_i,
  input  logic [ssdm_pkg::DATA_W-1:0]     data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ssdm_pkg::SEG_W-1:0]      segments_o,
  output logic [ssdm_pkg::EN_OUT_W-1:0]   digit_enables_o,
  output logic [ssdm_pkg::CUR_OUT_W-1:0]  cursor_o,
  output logic                            refreshed_o
);
  import ssdm_pkg::*;

  ssdm_cmd_t cmd;

  ssdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  ssdm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .data_i         (data_i),
    .segments_o     (segments_o),
    .digit_enables_o(digit_enables_o),
    .cursor_o       (cursor_o),
    .refreshed_o    (refreshed_o)
  );

  // second glyph write never overlaps a new item
  a_second_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.second |-> !in_ready_o)
    else $error("second glyph write while input open");

  // a waiting result is never overwritten
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  // a result only appears after a load
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("result valid without load");

endmodule

>>> rtl/core/ssdm_ctrl.sv
// control state machine: sequences one- and two-glyph items and the result register
module ssdm_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [ssdm_pkg::ACTION_W-1:0]   action_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ssdm_pkg::ssdm_cmd_t             cmd_o
);
  import ssdm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SECOND = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       two_step;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    case (action_i) inside
      ACT_HEX, ACT_DEC, ACT_DEC_BLANK: two_step = 1'b1;
      default: two_step = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (two_step) begin
            state_d = ST_SECOND;
          end else if (out_free) begin
            cmd_o.load_out = 1'b1;
          end else begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_SECOND: begin
        cmd_o.second = 1'b1;
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/ssdm_dp.sv
// datapath: glyph store, write cursor, scan position, output latches and result register
module ssdm_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ssdm_pkg::ssdm_cmd_t             cmd_i,
  input  logic [ssdm_pkg::ACTION_W-1:0]   action_i,
  input  logic [ssdm_pkg::DATA_W-1:0]     data_i,
  output logic [ssdm_pkg::SEG_W-1:0]      segments_o,
  output logic [ssdm_pkg::EN_OUT_W-1:0]   digit_enables_o,
  output logic [ssdm_pkg::CUR_OUT_W-1:0]  cursor_o,
  output logic                            refreshed_o
);
  import ssdm_pkg::*;

  logic [SEG_W-1:0]       glyph_q [DIGIT_COUNT];
  logic [SEG_W-1:0]       glyph_d [DIGIT_COUNT];
  logic [CUR_W-1:0]       cur_q, cur_d;
  logic [IDX_W-1:0]       scan_q, scan_d;
  logic [SEG_W-1:0]       seg_q, seg_d;
  logic [DIGIT_COUNT-1:0] en_q, en_d;
  logic                   tick_q, tick_d;
  logic [SEG_W-1:0]       second_q, second_d;

  logic [SEG_W-1:0]       seg_out_q;
  logic [EN_OUT_W-1:0]    en_out_q;
  logic [CUR_OUT_W-1:0]   cur_out_q;
  logic                   ref_out_q;

  logic [IDX_W-1:0]       scan_nxt;
  logic [CUR_W-1:0]       cur_m1;
  logic                   wr_en;
  logic [SEG_W-1:0]       wr_glyph;
  logic [6:0]             dec_sat;
  logic [14:0]            tens_prod;
  logic [3:0]             tens;
  logic [3:0]             units;
  logic [SEG_W-1:0]       dec_first;
  logic [DIGIT_COUNT+EN_OUT_W-1:0] en_ext;
  logic [CUR_W+CUR_OUT_W-1:0]      cur_ext;

  // divide by ten via reciprocal, exact for values up to 99
  assign dec_sat = (data_i > DATA_W'(DEC_MAX)) ? DEC_MAX : data_i[6:0];
  assign tens_prod = 15'(dec_sat) * 15'd205;
  assign tens = tens_prod[14:11];
  assign units = 4'(dec_sat - 7'(tens) * 7'd10);
  assign dec_first = ((action_i == ACT_DEC_BLANK) && (dec_sat < 7'd10)) ?
                     SEG_BLANK : hex_glyph(tens);

  assign scan_nxt = (scan_q == IDX_W'(DIGIT_COUNT - 1)) ? '0 : scan_q + 1'b1;
  assign cur_m1 = cur_q - 1'b1;

  always_comb begin
    glyph_d = glyph_q;
    cur_d = cur_q;
    scan_d = scan_q;
    seg_d = seg_q;
    en_d = en_q;
    tick_d = tick_q;
    second_d = second_q;
    wr_en = 1'b0;
    wr_glyph = SEG_BLANK;
    if (cmd_i.accept) begin
      tick_d = 1'b0;
      unique case (action_i) inside
        ACT_CHAR: begin
          if (data_i == CHAR_BLANK) begin
            wr_en = 1'b1;
            wr_glyph = SEG_BLANK;
          end else if (data_i == CHAR_MINUS) begin
            wr_en = 1'b1;
            wr_glyph = SEG_G;
          end else if (data_i == CHAR_POINT) begin
            if (cur_q != '0) begin
              glyph_d[cur_m1[IDX_W-1:0]] = glyph_q[cur_m1[IDX_W-1:0]] | SEG_DP;
            end
          end else begin
            wr_en = 1'b1;
            wr_glyph = hex_glyph(data_i[3:0]);
          end
        end
        ACT_HEX: begin
          wr_en = 1'b1;
          wr_glyph = hex_glyph(data_i[7:4]);
          second_d = hex_glyph(data_i[3:0]);
        end
        ACT_DEC, ACT_DEC_BLANK: begin
          wr_en = 1'b1;
          wr_glyph = dec_first;
          second_d = hex_glyph(units);
        end
        ACT_HOME: begin
          cur_d = '0;
        end
        ACT_CLEAR: begin
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            glyph_d[i] = SEG_BLANK;
          end
          cur_d = '0;
        end
        ACT_TICK: begin
          scan_d = scan_nxt;
          seg_d = glyph_q[scan_nxt];
          en_d = ~(DIGIT_COUNT'(1) << scan_nxt);
          tick_d = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.second) begin
      wr_en = 1'b1;
      wr_glyph = second_q;
    end
    // writes past the last digit are dropped
    if (wr_en && (cur_q < CUR_W'(DIGIT_COUNT))) begin
      glyph_d[cur_q[IDX_W-1:0]] = wr_glyph;
      cur_d = cur_q + 1'b1;
    end
  end

  assign en_ext = (DIGIT_COUNT + EN_OUT_W)'(en_d);
  assign cur_ext = (CUR_W + CUR_OUT_W)'(cur_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        glyph_q[i] <= SEG_BLANK;
      end
      cur_q <= '0;
      scan_q <= '0;
      seg_q <= '0;
      en_q <= '1;
      tick_q <= 1'b0;
    end else begin
      glyph_q <= glyph_d;
      cur_q <= cur_d;
      scan_q <= scan_d;
      seg_q <= seg_d;
      en_q <= en_d;
      tick_q <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    second_q <= second_d;
    if (cmd_i.load_out) begin
      seg_out_q <= seg_d;
      en_out_q <= en_ext[EN_OUT_W-1:0];
      cur_out_q <= cur_ext[CUR_OUT_W-1:0];
      ref_out_q <= tick_d;
    end
  end

  assign segments_o = seg_out_q;
  assign digit_enables_o = en_out_q;
  assign cursor_o = cur_out_q;
  assign refreshed_o = ref_out_q;

endmodule
